>>> rtl/core/graded_mesh_node_generator_unit_defines.svh
// Assertion macros shared by the graded mesh node generator RTL.
// The macros expect clk_i and rst_ni to be visible in the module that uses them.
`ifndef GRADED_MESH_NODE_GENERATOR_UNIT_DEFINES_SVH
`define GRADED_MESH_NODE_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMNG_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMNG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gmng_pkg.sv
// Package of the graded mesh node generator: widths, codes, states and types.
// No dependencies; gmng_div, the top level and the testbench import it.
`default_nettype none

package gmng_pkg;

  localparam int unsigned IdxW = 11;   // node index and cell count
  localparam int unsigned PowW = 60;   // Q28 powers stay below 2^60
  localparam int unsigned DenW = 62;   // divisor of a node division
  localparam int unsigned DvdW = 95;   // L * a + d/2 stays below 2^95
  localparam int unsigned QW   = 33;   // quotient bits the divider produces

  localparam logic [PowW-1:0] OneQ28  = 60'h000_0000_1000_0000;
  localparam logic [31:0]     OneQ28R = 32'h1000_0000;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OVERFLOW   = 3'd1,
    ST_ZERO_WIDTH = 3'd2,
    ST_BELOW_MIN  = 3'd3,
    ST_RANGE      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CFG_CELL_COUNT = 3'd0,
    CFG_AXIS_LEN   = 3'd1,
    CFG_MODE       = 3'd2,
    CFG_RATIO      = 3'd3,
    CFG_SIDE       = 3'd4,
    CFG_MIN_WIDTH  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SIDE_START = 2'd0,
    SIDE_END   = 2'd1,
    SIDE_BOTH  = 2'd2,
    SIDE_UNIF  = 2'd3
  } side_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PSTEP,
    S_PMUL_HI,
    S_PMUL_LO,
    S_PCHK,
    S_DEN,
    S_NMUL_HI,
    S_NMUL_LO,
    S_DIV_START,
    S_DIV_WAIT,
    S_NODE_UPD,
    S_MID_W,
    S_MIN_MUL,
    S_MIN_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/gmng_if.sv
// Stream interfaces of the graded mesh node generator: query in, result out.
// Depends on nothing; valid/ready handshake, one transaction per edge with both high.
`default_nettype none

interface gmng_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] node_index;

  modport source (output valid, output node_index, input ready);
  modport sink   (input valid, input node_index, output ready);
endinterface

interface gmng_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] node_coord;
  logic [2:0]  grading_status;

  modport source (output valid, output node_coord, output grading_status, input ready);
  modport sink   (input valid, input node_coord, input grading_status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gmng_mul32.sv
// Shared 32 x 32 multiplier with a registered product.
// Depends on nothing but its operands.
`default_nettype none

module gmng_mul32 (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> rtl/core/gmng_div.sv
// Bit-serial restoring divider for round(L * a / d), one quotient bit per cycle.
// Depends on gmng_pkg; the caller guarantees dividend >> 33 is below the divisor.
`default_nettype none

module gmng_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gmng_pkg::DvdW-1:0] dividend_i,
  input  logic [gmng_pkg::DenW-1:0] divisor_i,
  output logic [gmng_pkg::QW-1:0]   quot_o,
  output gmng_pkg::div_stat_t       stat_o
);
  import gmng_pkg::*;

  localparam int unsigned CntW = $clog2(QW + 1);

  logic [DenW-1:0] rem_q, dv_q;
  logic [QW-1:0]   sh_q, q_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  logic [DenW:0]   trial;
  logic [DenW+1:0] diff;
  logic            ge;

  // The upper dividend bits already lie below the divisor, so only the
  // low QW bits need a trial subtraction.
  assign trial = {rem_q, sh_q[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dv_q};
  assign ge    = ~diff[DenW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DvdW-1:QW];
      sh_q  <= dividend_i[QW-1:0];
      dv_q  <= divisor_i;
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      sh_q  <= {sh_q[QW-2:0], 1'b0};
      q_q   <= {q_q[QW-2:0], ge};
    end
  end

  assign quot_o      = q_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

>>> rtl/core/graded_mesh_node_generator_unit.sv
// Graded mesh node generator: a query carries a node index, the result carries
// that node's Q16.16 coordinate on the configured axis and a status code.
// Channels: in_i (node_index) and out_o (node_coord, grading_status), both
// valid/ready; a transaction happens at an edge with valid and ready high.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i, to be written only while
// idle; the block does not enforce it. One query is worked at a time;
// in_i.ready is high only in the idle state. An index out of range or a zero
// length goes straight to the result; a uniform node takes two multiplier
// passes and 33 divider steps. Geometric mode checks the whole node set: a
// power pass (none for the uniform side) and a node pass over T = cell count
// (half of it for both-ends clustering).
// The result sits in an output register; a new query may start while it
// waits, and a finished query holds in its last state until the register
// frees. A stalled receiver therefore stalls the block after one query.
// Reset loads the default axis (one cell, length 1.0, uniform) and empties
// the output register.
`default_nettype none

module graded_mesh_node_generator_unit #(
  parameter int unsigned MAX_CELLS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  gmng_in_if.sink          in_i,
  gmng_out_if.source       out_o
);
  import gmng_pkg::*;
  `include "graded_mesh_node_generator_unit_defines.svh"

  // Configuration registers.
  logic [IdxW-1:0] cc_q;
  logic [31:0]     len_q, ratio_q, mrw_q;
  logic            mode_q;
  logic [1:0]      side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q    <= 11'd1;
      len_q   <= 32'd65536;
      mode_q  <= 1'b0;
      ratio_q <= 32'd268435456;
      side_q  <= 2'd0;
      mrw_q   <= 32'd4295;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CELL_COUNT: cc_q    <= cfg_data_i[IdxW-1:0];
        CFG_AXIS_LEN:   len_q   <= cfg_data_i;
        CFG_MODE:       mode_q  <= cfg_data_i[0];
        CFG_RATIO:      ratio_q <= cfg_data_i;
        CFG_SIDE:       side_q  <= cfg_data_i[1:0];
        CFG_MIN_WIDTH:  mrw_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective axis.
  logic [IdxW-1:0] n_eff, m_half;
  logic            n_odd, r_gt_one;
  side_e           side;

  always_comb begin
    if (cc_q == '0) begin
      n_eff = IdxW'(1);
    end else if (32'(cc_q) > MAX_CELLS) begin
      n_eff = IdxW'(MAX_CELLS);
    end else begin
      n_eff = cc_q;
    end
  end
  assign m_half   = n_eff >> 1;
  assign n_odd    = n_eff[0];
  assign r_gt_one = ratio_q > OneQ28R;
  assign side     = side_e'(side_q);

  // Sequencer registers.
  state_e          state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, top_q, top_d, kk_q, kk_d;
  logic            flip_q, flip_d, idx_src_q, idx_src_d, single_q, single_d;
  logic            node_ph_q, node_ph_d, mid_ph_q, mid_ph_d, zero_q, zero_d;
  logic [PowW-1:0] p_q, p_d, th_q, th_d, mid_q, mid_d;
  logic [DenW-1:0] d_q, d_d;
  logic [31:0]     ypp_q, ypp_d, yprev_q, yprev_d, small_q, small_d, cap_q, cap_d;
  status_e         status_q, status_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_coord_q, out_coord_d;
  logic [2:0]      out_status_q, out_status_d;

  // Shared units.
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod;
  logic            div_start;
  logic [DvdW-1:0] dividend;
  logic [QW-1:0]   quot;
  div_stat_t       div_st;

  gmng_mul32 u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  gmng_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (d_q),
    .quot_o     (quot),
    .stat_o     (div_st)
  );

  // Datapath terms.
  logic [31:0]     r_sel;
  logic [64:0]     lo_sum;
  logic [PowW:0]   v_pow;
  logic            pow_fail;
  logic [PowW-1:0] pm1, a_val;
  logic [31:0]     y, w, y_a;
  logic [33:0]     mid_w;
  logic [IdxW-1:0] k_in;

  assign r_sel    = mid_ph_q ? (ratio_q - OneQ28R) : ratio_q;
  assign lo_sum   = {1'b0, prod} + 65'h0_0800_0000;
  assign v_pow    = {1'b0, th_q[PowW-5:0], 4'b0000} + {24'b0, lo_sum[64:28]};
  assign pow_fail = (|th_q[PowW-1:PowW-4]) | v_pow[PowW];
  assign pm1      = p_q - OneQ28;
  assign a_val    = idx_src_q ? {{(PowW-IdxW){1'b0}}, i_q} : pm1;
  assign dividend = {3'b000, th_q, 32'b0} + {31'b0, prod} + {34'b0, d_q[DenW-1:1]};
  assign y        = quot[31:0];
  assign w        = y - yprev_q;
  assign y_a      = n_odd ? yprev_q : ypp_q;
  assign mid_w    = {2'b00, len_q} - {2'b00, y_a} - {2'b00, yprev_q};
  assign k_in     = in_i.node_index;

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    top_d        = top_q;
    kk_d         = kk_q;
    flip_d       = flip_q;
    idx_src_d    = idx_src_q;
    single_d     = single_q;
    node_ph_d    = node_ph_q;
    mid_ph_d     = mid_ph_q;
    zero_d       = zero_q;
    p_d          = p_q;
    th_d         = th_q;
    mid_d        = mid_q;
    d_d          = d_q;
    ypp_d        = ypp_q;
    yprev_d      = yprev_q;
    small_d      = small_q;
    cap_d        = cap_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_coord_d  = out_coord_q;
    out_status_d = out_status_q;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    in_i.ready   = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          zero_d    = 1'b0;
          small_d   = len_q;
          status_d  = ST_OK;
          cap_d     = '0;
          flip_d    = 1'b0;
          kk_d      = k_in;
          single_d  = 1'b0;
          idx_src_d = 1'b0;
          node_ph_d = 1'b0;
          mid_ph_d  = 1'b0;
          p_d       = OneQ28;
          i_d       = '0;
          if (k_in > n_eff) begin
            status_d = ST_RANGE;
            state_d  = S_DONE;
          end else if (len_q == '0) begin
            status_d = ST_ZERO_WIDTH;
            state_d  = S_DONE;
          end else if (!mode_q || !r_gt_one) begin
            single_d  = 1'b1;
            idx_src_d = 1'b1;
            i_d       = k_in;
            d_d       = {{(DenW-IdxW){1'b0}}, n_eff};
            state_d   = S_NMUL_HI;
          end else if (side == SIDE_UNIF) begin
            idx_src_d = 1'b1;
            node_ph_d = 1'b1;
            top_d     = n_eff;
            d_d       = {{(DenW-IdxW){1'b0}}, n_eff};
            state_d   = S_NMUL_HI;
          end else begin
            top_d   = (side == SIDE_BOTH) ? m_half : n_eff;
            state_d = S_PSTEP;
            if (side == SIDE_END) begin
              kk_d   = n_eff - k_in;
              flip_d = 1'b1;
            end else if (side == SIDE_BOTH && k_in > m_half) begin
              kk_d   = n_eff - k_in;
              flip_d = 1'b1;
            end
          end
        end
      end

      S_PSTEP: begin
        if (i_q == top_q) begin
          if (side == SIDE_BOTH && n_odd) begin
            mid_ph_d = 1'b1;
            state_d  = S_PMUL_HI;
          end else begin
            state_d = S_DEN;
          end
        end else begin
          state_d = S_PMUL_HI;
        end
      end

      S_PMUL_HI: begin
        mul_a   = {4'b0000, p_q[PowW-1:32]};
        mul_b   = r_sel;
        state_d = S_PMUL_LO;
      end

      S_PMUL_LO: begin
        th_d    = prod[PowW-1:0];
        mul_a   = p_q[31:0];
        mul_b   = r_sel;
        state_d = S_PCHK;
      end

      S_PCHK: begin
        if (pow_fail) begin
          status_d = ST_OVERFLOW;
          state_d  = S_DONE;
        end else if (mid_ph_q) begin
          mid_d   = v_pow[PowW-1:0];
          state_d = S_DEN;
        end else begin
          p_d     = v_pow[PowW-1:0];
          i_d     = i_q + 1'b1;
          state_d = node_ph_q ? S_NMUL_HI : S_PSTEP;
        end
      end

      S_DEN: begin
        if (side == SIDE_BOTH) begin
          d_d = {1'b0, pm1, 1'b0} + (n_odd ? {2'b00, mid_q} : '0);
        end else begin
          d_d = {2'b00, pm1};
        end
        p_d       = OneQ28;
        i_d       = '0;
        node_ph_d = 1'b1;
        mid_ph_d  = 1'b0;
        state_d   = S_NMUL_HI;
      end

      S_NMUL_HI: begin
        mul_a   = len_q;
        mul_b   = {4'b0000, a_val[PowW-1:32]};
        state_d = S_NMUL_LO;
      end

      S_NMUL_LO: begin
        th_d    = prod[PowW-1:0];
        mul_a   = len_q;
        mul_b   = a_val[31:0];
        state_d = S_DIV_START;
      end

      S_DIV_START: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_st.done) begin
          state_d = S_NODE_UPD;
        end
      end

      S_NODE_UPD: begin
        if (single_q) begin
          cap_d   = y;
          state_d = S_DONE;
        end else begin
          if (i_q != '0) begin
            if (y <= yprev_q) begin
              zero_d = 1'b1;
            end else if (w < small_q) begin
              small_d = w;
            end
          end
          ypp_d   = yprev_q;
          yprev_d = y;
          if (i_q == kk_q) begin
            cap_d = y;
          end
          if (i_q == top_q) begin
            state_d = (side == SIDE_BOTH) ? S_MID_W : S_MIN_MUL;
          end else if (idx_src_q) begin
            i_d     = i_q + 1'b1;
            state_d = S_NMUL_HI;
          end else begin
            state_d = S_PMUL_HI;
          end
        end
      end

      // The middle cell of a both-ends axis (odd count) or the one past the middle.
      S_MID_W: begin
        if (mid_w[33] || mid_w == '0) begin
          zero_d = 1'b1;
        end else if (mid_w[31:0] < small_q) begin
          small_d = mid_w[31:0];
        end
        state_d = S_MIN_MUL;
      end

      S_MIN_MUL: begin
        mul_a   = mrw_q;
        mul_b   = len_q;
        state_d = S_MIN_CHK;
      end

      S_MIN_CHK: begin
        if (zero_q) begin
          status_d = ST_ZERO_WIDTH;
        end else if ({small_q, 32'b0} < prod) begin
          status_d = ST_BELOW_MIN;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          if (status_q != ST_OK) begin
            out_coord_d = '0;
          end else begin
            out_coord_d = flip_q ? (len_q - cap_q) : cap_q;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    top_q        <= top_d;
    kk_q         <= kk_d;
    flip_q       <= flip_d;
    idx_src_q    <= idx_src_d;
    single_q     <= single_d;
    node_ph_q    <= node_ph_d;
    mid_ph_q     <= mid_ph_d;
    zero_q       <= zero_d;
    p_q          <= p_d;
    th_q         <= th_d;
    mid_q        <= mid_d;
    d_q          <= d_d;
    ypp_q        <= ypp_d;
    yprev_q      <= yprev_d;
    small_q      <= small_d;
    cap_q        <= cap_d;
    status_q     <= status_d;
    out_coord_q  <= out_coord_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.node_coord     = out_coord_q;
  assign out_o.grading_status = out_status_q;

  `GMNG_ASSERT(div_done_in_wait_a, div_st.done, state_q == S_DIV_WAIT, "divider finished outside its wait state")
  `GMNG_ASSERT_NEXT(div_busy_after_start_a, state_q == S_DIV_START, div_st.busy, "divider not busy after start")
  `GMNG_ASSERT(coord_zero_on_fault_a, out_valid_q && out_status_q != ST_OK, out_coord_q == '0, "nonzero coordinate with a fault status")
  `GMNG_ASSERT(status_code_a, out_valid_q, out_status_q <= ST_RANGE, "status code beyond the defined set")

endmodule

`default_nettype wire

>>> dv/tb_graded_mesh_node_generator_unit.sv
// Testbench of the graded mesh node generator: random axis settings, node queries
// with random gaps and receiver stalls, results checked against an in-bench predictor.
// Depends on gmng_pkg, the gmng_in_if/gmng_out_if interfaces and the RTL top level.
`default_nettype none

module tb_graded_mesh_node_generator_unit;
  import gmng_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] coord;
    status_e     st;
  } node_result_t;

  class node_scoreboard;
    logic [10:0]  cells;
    logic [31:0]  len;
    logic         geometric;
    logic [31:0]  ratio;
    side_e        side;
    logic [31:0]  min_width;
    node_result_t expected_nodes[$];
    int           errors;
    logic [59:0]  pw[0:1024];
    logic [31:0]  xs[0:1024];

    function void defaults();
      cells = 11'd1; len = 32'd65536; geometric = 1'b0;
      ratio = OneQ28R; side = SIDE_START; min_width = 32'd4295;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] v);
      case (idx)
        CFG_CELL_COUNT: cells = v[10:0];
        CFG_AXIS_LEN:   len = v;
        CFG_MODE:       geometric = v[0];
        CFG_RATIO:      ratio = v;
        CFG_SIDE:       side = side_e'(v[1:0]);
        CFG_MIN_WIDTH:  min_width = v;
        default: ;
      endcase
    endfunction

    // Rounded Q28 product; a result of 2^60 or more is an overflow.
    function bit pow_step(logic [59:0] p, logic [31:0] r, output logic [59:0] res);
      logic [127:0] t;
      t = ({68'd0, p} * {96'd0, r} + 128'd134217728) >> 28;
      res = t[59:0];
      return t < (128'd1 << 60);
    endfunction

    function logic [31:0] scale(logic [31:0] l, logic [63:0] a, logic [63:0] d);
      logic [127:0] t;
      t = ({96'd0, l} * {64'd0, a} + {64'd0, d >> 1}) / {64'd0, d};
      return t[31:0];
    endfunction

    function logic [31:0] uniform_node(int unsigned k, int unsigned n);
      logic [63:0] t;
      t = (64'(k) * 64'(len) + 64'(n / 2)) / 64'(n);
      return t[31:0];
    endfunction

    function node_result_t predict(logic [10:0] k);
      node_result_t res;
      int unsigned  n, top, m;
      logic [63:0]  d;
      logic [59:0]  mid;
      logic [31:0]  smallest, w;
      status_e      st;
      n = cells;
      if (n == 0) n = 1;
      if (n > 1024) n = 1024;
      res.coord = 32'd0;
      if (k > n) begin
        res.st = ST_RANGE;
        return res;
      end
      if (len == 0) begin
        res.st = ST_ZERO_WIDTH;
        return res;
      end
      if (!geometric || ratio <= OneQ28R) begin
        res.coord = uniform_node(k, n);
        res.st = ST_OK;
        return res;
      end
      if (side == SIDE_UNIF) begin
        for (int i = 0; i <= n; i++) xs[i] = uniform_node(i, n);
      end else begin
        top = (side == SIDE_BOTH) ? n / 2 : n;
        pw[0] = OneQ28;
        for (int i = 1; i <= top; i++) begin
          if (!pow_step(pw[i-1], ratio, pw[i])) begin
            res.st = ST_OVERFLOW;
            return res;
          end
        end
        if (side == SIDE_BOTH) begin
          m = n / 2;
          d = 64'(pw[m] - OneQ28) << 1;
          if (n % 2 == 1) begin
            if (!pow_step(pw[m], ratio - OneQ28R, mid)) begin
              res.st = ST_OVERFLOW;
              return res;
            end
            d += 64'(mid);
          end
          for (int i = 0; i <= m; i++) xs[i] = scale(len, 64'(pw[i] - OneQ28), d);
          for (int i = m + 1; i <= n; i++) xs[i] = len - xs[n-i];
        end else begin
          d = 64'(pw[n] - OneQ28);
          for (int i = 0; i <= n; i++) begin
            if (side == SIDE_START) xs[i] = scale(len, 64'(pw[i] - OneQ28), d);
            else xs[i] = len - scale(len, 64'(pw[n-i] - OneQ28), d);
          end
        end
      end
      st = ST_OK;
      smallest = len;
      for (int i = 0; i < n; i++) begin
        if (xs[i+1] <= xs[i]) begin
          st = ST_ZERO_WIDTH;
          break;
        end
        w = xs[i+1] - xs[i];
        if (w < smallest) smallest = w;
      end
      if (st == ST_OK && ({smallest, 32'd0} < 64'(min_width) * 64'(len))) st = ST_BELOW_MIN;
      res.st = st;
      res.coord = (st == ST_OK) ? xs[k] : 32'd0;
      return res;
    endfunction

    function void note_query(logic [10:0] k);
      expected_nodes.push_back(predict(k));
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] coord, logic [2:0] st);
      node_result_t e;
      if (expected_nodes.size() == 0) begin
        report($sformatf("unexpected result coord=%h status=%0d", coord, st));
        return;
      end
      e = expected_nodes.pop_front();
      if (coord !== e.coord)
        report($sformatf("node_coord %h, expected %h", coord, e.coord));
      if (st !== e.st)
        report($sformatf("grading_status %0d, expected %0d", st, e.st));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  gmng_in_if  in_if();
  gmng_out_if out_if();

  graded_mesh_node_generator_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  node_scoreboard sb;
  int             queries_sent;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12ns * 20_000_000);
    $display("** graded_mesh_node_generator_unit: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.node_coord, out_if.grading_status);
  end

  // Receiver backpressure: mostly short stalls, a few long ones, some long open runs.
  initial begin
    int unsigned run, gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
      out_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      out_if.ready <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  end

  function int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return 0;
    if (sel < 19) return $urandom_range(1, 4);
    return $urandom_range(20, 100);
  endfunction

  task wait_idle();
    while (sb.expected_nodes.size() != 0) @(posedge clk_i);
  endtask

  // The write enable stays high across back-to-back writes; the caller drops it.
  task write_reg(cfg_idx_e idx, logic [31:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  // Upper bits of the narrow registers get random values; the block ignores them.
  task program_axis(logic [10:0] n, logic [31:0] l, logic g, logic [31:0] r,
                    side_e s, logic [31:0] mw);
    logic [31:0] junk;
    wait_idle();
    junk = $urandom;
    write_reg(CFG_CELL_COUNT, {junk[31:11], n});
    write_reg(CFG_AXIS_LEN, l);
    write_reg(CFG_MODE, {junk[30:0], g});
    write_reg(CFG_RATIO, r);
    write_reg(CFG_SIDE, {junk[29:0], s});
    write_reg(CFG_MIN_WIDTH, mw);
    cfg_we_i <= 1'b0;
  endtask

  task send_query(logic [10:0] k, bit last);
    int unsigned gap;
    in_if.valid      <= 1'b1;
    in_if.node_index <= k;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_query(k);
    queries_sent++;
    gap = pick_gap();
    if (gap > 0 || last) in_if.valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task run_queries(int unsigned count);
    int unsigned n;
    logic [10:0] k;
    n = (sb.cells == 0) ? 1 : ((sb.cells > 1024) ? 1024 : sb.cells);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) k = $urandom_range(0, n);
      else k = $urandom_range(0, 2047);
      send_query(k, i == count - 1);
    end
  endtask

  task random_axis();
    logic [10:0] n;
    logic [31:0] l, r, mw;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    n = (sel < 8) ? $urandom_range(1, 8) : ((sel < 9) ? $urandom_range(0, 40) :
        $urandom_range(0, 2047));
    sel = $urandom_range(0, 9);
    l = (sel == 0) ? $urandom_range(0, 40) : ((sel == 1) ? 32'hffff_ffff : $urandom);
    sel = $urandom_range(0, 9);
    if (sel == 0) r = $urandom_range(0, OneQ28R);
    else if (sel < 7) r = OneQ28R + $urandom_range(1, 32'h0800_0000);
    else r = $urandom_range(OneQ28R, 32'hffff_ffff);
    sel = $urandom_range(0, 5);
    mw = (sel == 0) ? 32'd0 : ((sel == 1) ? $urandom : $urandom_range(0, 32'h0100_0000));
    // Geometric mode only on small axes keeps the run time bounded.
    program_axis(n, l, (n <= 40) ? 1'($urandom) : 1'b0, r, side_e'($urandom_range(0, 3)),
                 mw);
  endtask

  initial begin
    sb = new();
    sb.defaults();
    queries_sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CELL_COUNT;
    cfg_data_i = 32'd0;
    in_if.valid = 1'b0;
    in_if.node_index = 11'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset axis, then range edges.
    send_query(11'd0, 0); send_query(11'd1, 0); send_query(11'd2, 0);
    send_query(11'd2047, 1);
    // Cell count zero and the largest count, uniform, full length.
    program_axis(11'd0, 32'hffff_ffff, 1'b0, OneQ28R, SIDE_START, 32'd0);
    send_query(11'd1, 0); send_query(11'd2, 1);
    program_axis(11'd2047, 32'hffff_ffff, 1'b0, OneQ28R, SIDE_START, 32'hffff_ffff);
    send_query(11'd512, 0); send_query(11'd1024, 0); send_query(11'd1025, 1);
    // Each cluster side, with odd and even counts for both ends.
    program_axis(11'd5, 32'h0010_0000, 1'b1, 32'h1333_3333, SIDE_START, 32'd0);
    send_query(11'd3, 0); send_query(11'd5, 1);
    program_axis(11'd5, 32'h0010_0000, 1'b1, 32'h1333_3333, SIDE_END, 32'd0);
    send_query(11'd2, 1);
    program_axis(11'd7, 32'h0010_0000, 1'b1, 32'h1800_0000, SIDE_BOTH, 32'd4295);
    send_query(11'd3, 0); send_query(11'd7, 1);
    program_axis(11'd6, 32'h0010_0000, 1'b1, 32'h1800_0000, SIDE_BOTH, 32'd4295);
    send_query(11'd4, 1);
    program_axis(11'd4, 32'h0010_0000, 1'b1, 32'h1800_0000, SIDE_UNIF, 32'd4295);
    send_query(11'd1, 1);
    // Ratio below one, overflow, zero length, zero-width cells, minimum violated.
    program_axis(11'd4, 32'h0010_0000, 1'b1, 32'h0800_0000, SIDE_START, 32'd0);
    send_query(11'd2, 1);
    program_axis(11'd10, 32'h0010_0000, 1'b1, 32'hffff_ffff, SIDE_START, 32'd0);
    send_query(11'd3, 1);
    program_axis(11'd9, 32'h0010_0000, 1'b1, 32'hffff_ffff, SIDE_BOTH, 32'd0);
    send_query(11'd3, 1);
    program_axis(11'd4, 32'd0, 1'b1, 32'h1800_0000, SIDE_START, 32'd0);
    send_query(11'd1, 1);
    program_axis(11'd4, 32'd1, 1'b1, 32'h1800_0000, SIDE_START, 32'd0);
    send_query(11'd1, 1);
    program_axis(11'd4, 32'h0010_0000, 1'b1, 32'h1800_0000, SIDE_END, 32'hffff_ffff);
    send_query(11'd1, 1);
    // One full-size geometric axis.
    program_axis(11'd1024, 32'hffff_ffff, 1'b1, 32'h1001_0000, SIDE_BOTH, 32'd0);
    send_query(11'd700, 1);

    while (queries_sent < 1320) begin
      random_axis();
      run_queries($urandom_range(10, 40));
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_nodes.size() == 0) begin
      $display("** graded_mesh_node_generator_unit: PASSED **");
    end else begin
      $display("** graded_mesh_node_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
